// ===== sv/fta_pkg.sv =====
// Shared types and constants of the frame time averager.
// No dependencies; compile this file first.
`timescale 1ns / 1ps

package fta_pkg;

  localparam int STAMP_W = 32;
  localparam int RATE_W  = 16;
  localparam int ACC_W   = STAMP_W + 1;

  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [RATE_W-1:0]  rate_t;
  typedef logic [ACC_W-1:0]   acc_t;

  localparam stamp_t TPS_RESET = stamp_t'(1000);
  localparam rate_t  RATE_MAX  = '1;

endpackage

// ===== sv/fta_channels.sv =====
// Handshake channels of the frame time averager: timer stamps in, results out,
// and the register write channel. Depends on fta_pkg.
`timescale 1ns / 1ps

interface fta_in_if;
  import fta_pkg::*;
  logic   valid;
  logic   ready;
  stamp_t timestamp;

  modport source (output valid, output timestamp, input ready);
  modport sink   (input valid, input timestamp, output ready);
endinterface

interface fta_out_if;
  import fta_pkg::*;
  logic   valid;
  logic   ready;
  stamp_t average_elapsed;
  rate_t  frame_rate;

  modport source (output valid, output average_elapsed, output frame_rate, input ready);
  modport sink   (input valid, input average_elapsed, input frame_rate, output ready);
endinterface

interface fta_cfg_if;
  import fta_pkg::*;
  logic   valid;
  logic   ready;
  stamp_t ticks_per_second;

  modport source (output valid, output ticks_per_second, input ready);
  modport sink   (input valid, input ticks_per_second, output ready);
endinterface

// ===== sv/fta_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module fta_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/fta_divider.sv =====
// Restoring divider that produces one quotient bit per cycle.
// No dependencies; used by the frame time averager top level.
`timescale 1ns / 1ps

module fta_divider #(
  parameter int DIVIDEND_W = 36,
  parameter int DIVISOR_W  = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic                  busy;
  logic [STEP_W-1:0]     steps;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVIDEND_W-1:0] work;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  // The dividend shifts out at the top while quotient bits shift in below.
  assign trial    = {rem, work[DIVIDEND_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIVIDEND_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs  <= divisor;
      rem  <= '0;
      work <= dividend;
    end else if (busy) begin
      rem  <= fits ? DIVISOR_W'(trial - {1'b0, dvs}) : trial[DIVISOR_W-1:0];
      work <= {work[DIVIDEND_W-2:0], fits};
    end
  end

endmodule

// ===== sv/frame_time_averager.sv =====
// Top level of the frame time averager: window bookkeeping, frame rate
// counting and result register. Depends on fta_pkg, fta_channels, fta_ram
// and fta_divider.
`timescale 1ns / 1ps

// Usage
// Each transfer on frame_in is one frame tick carrying the free-running timer
// value. The elapsed time since the previous tick is checked against the
// current average and, when it lies within one second of it, enters a window
// of the newest WINDOW_DEPTH samples held in a small RAM. Every tick yields one
// transfer on result_out with the windowed average frame time and the frame
// rate latched at the end of the last completed one-second span.
// The cfg channel writes ticks_per_second; it is always ready and must only be
// written while no tick is in flight.
// Timing: a tick is accepted only while the block is idle. The accepting edge
// launches the read of the oldest window entry, the next cycle updates the
// window, then the bit-serial divider works out sum over count bit by bit,
// one quotient bit per sum bit. The S_DIV state then takes the quotient as the
// new average and the S_OUT state loads the output register once it is free;
// only then does the block return to idle and accept the next tick.
// If the receiver stalls, the result waits in the output register while one
// further tick is accepted and processed; that second result then waits in the
// block and no more ticks are accepted until the output register is free.
// Reset clears all counters, the average and the window pointer at once; the
// window RAM needs no clearing: a read entry is used only once all are written.

module frame_time_averager #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  fta_in_if.sink     frame_in,
  fta_out_if.source  result_out,
  fta_cfg_if.sink    cfg
);

  import fta_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W = STAMP_W + CNT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RMW  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state;

  // Register and architectural state.
  stamp_t             ticks_per_second;
  stamp_t             last_stamp;
  stamp_t             average_ticks;
  logic [CNT_W-1:0]   sample_count;
  logic [SUM_W-1:0]   window_sum;
  logic [PTR_W-1:0]   wr_ptr;
  rate_t              frames_in_second;
  acc_t               second_accumulator;
  rate_t              latched_rate;

  // Per-tick working registers.
  stamp_t             elapsed;
  logic               keep;

  // Accept-cycle arithmetic.
  logic               accept;
  stamp_t             elapsed_now;
  stamp_t             diff_now;
  rate_t              frames_inc;
  acc_t               acc_sum;

  // Window update arithmetic.
  logic               full;
  stamp_t             oldest;
  logic [SUM_W-1:0]   window_sum_next;
  logic [CNT_W-1:0]   sample_count_next;
  logic               ram_we;

  // Divider.
  logic               div_start;
  logic               div_done;
  logic [SUM_W-1:0]   div_quotient;

  // Output register.
  logic               out_valid;
  stamp_t             out_average;
  rate_t              out_rate;
  logic               out_free;

  assign cfg.ready      = 1'b1;
  assign frame_in.ready = (state == S_IDLE);
  assign accept         = frame_in.valid && frame_in.ready;

  assign result_out.valid           = out_valid;
  assign result_out.average_elapsed = out_average;
  assign result_out.frame_rate      = out_rate;
  assign out_free                   = !out_valid || result_out.ready;

  // Outlier test against the average left by the previous tick.
  assign elapsed_now = frame_in.timestamp - last_stamp;
  assign diff_now    = (elapsed_now >= average_ticks) ? (elapsed_now - average_ticks)
                                                      : (average_ticks - elapsed_now);
  assign frames_inc  = (frames_in_second != RATE_MAX) ? frames_in_second + 1'b1
                                                      : frames_in_second;
  assign acc_sum     = second_accumulator + {1'b0, average_ticks};

  // The oldest sample sits in the slot the write pointer is about to reuse.
  assign full              = (sample_count == CNT_W'(WINDOW_DEPTH));
  assign window_sum_next   = window_sum - (full ? {{CNT_W{1'b0}}, oldest} : '0)
                             + {{CNT_W{1'b0}}, elapsed};
  assign sample_count_next = full ? sample_count : sample_count + 1'b1;
  assign ram_we            = (state == S_RMW) && keep;
  assign div_start         = (state == S_RMW);

  fta_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata (elapsed),
    .re    (accept),
    .raddr (wr_ptr),
    .rdata (oldest)
  );

  fta_divider #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (keep ? window_sum_next : window_sum),
    .divisor  (keep ? sample_count_next : sample_count),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      ticks_per_second   <= TPS_RESET;
      last_stamp         <= '0;
      average_ticks      <= '0;
      sample_count       <= '0;
      window_sum         <= '0;
      wr_ptr             <= '0;
      frames_in_second   <= '0;
      second_accumulator <= '0;
      latched_rate       <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (cfg.valid) begin
        ticks_per_second <= cfg.ticks_per_second;
      end

      if (out_valid && result_out.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            last_stamp <= frame_in.timestamp;
            // The rate counter runs on the previous average, not the new sample.
            if (acc_sum > {1'b0, ticks_per_second}) begin
              latched_rate       <= frames_inc;
              frames_in_second   <= '0;
              second_accumulator <= '0;
            end else begin
              frames_in_second   <= frames_inc;
              second_accumulator <= acc_sum;
            end
            state <= S_RMW;
          end
        end
        S_RMW: begin
          if (keep) begin
            window_sum   <= window_sum_next;
            sample_count <= sample_count_next;
            wr_ptr       <= (wr_ptr == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
          end
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            average_ticks <= (sample_count == '0) ? '0 : div_quotient[STAMP_W-1:0];
            state         <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      elapsed <= elapsed_now;
      keep    <= diff_now < ticks_per_second;
    end
    if ((state == S_OUT) && out_free) begin
      out_average <= average_ticks;
      out_rate    <= latched_rate;
    end
  end

endmodule

// ===== tb/fta_checker.sv =====
// Checker of the frame time averager: watches the stamp, result and register
// channels, predicts each result and compares it field by field.
// Depends on fta_pkg and fta_channels.
`timescale 1ns / 1ps

module fta_checker #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  fta_in_if    frame_ch,
  fta_out_if   result_ch,
  fta_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending_results
);
  import fta_pkg::*;

  localparam int SUM_W = STAMP_W + $clog2(WINDOW_DEPTH);

  typedef struct packed {
    stamp_t average_elapsed;
    rate_t  frame_rate;
  } frame_result_t;

  frame_result_t     awaited_results[$];
  stamp_t            second_ticks;
  stamp_t            prev_stamp;
  stamp_t            running_average;
  stamp_t            samples[WINDOW_DEPTH];
  int unsigned       kept_samples;
  logic [SUM_W-1:0]  sample_sum;
  rate_t             frames_seen;
  rate_t             held_rate;
  acc_t              average_acc;
  int                errors = 0;

  // Advances the predicted state by one frame tick and returns its result.
  function automatic frame_result_t average_frame(input stamp_t stamp);
    stamp_t        elapsed;
    stamp_t        gap;
    stamp_t        prior;
    frame_result_t res;
    prior      = running_average;
    elapsed    = stamp - prev_stamp;
    prev_stamp = stamp;
    gap = (elapsed >= prior) ? elapsed - prior : prior - elapsed;
    if (gap < second_ticks) begin
      if (kept_samples >= WINDOW_DEPTH) begin
        sample_sum = sample_sum - samples[WINDOW_DEPTH-1];
      end
      for (int k = WINDOW_DEPTH - 1; k > 0; k--) begin
        samples[k] = samples[k-1];
      end
      samples[0] = elapsed;
      sample_sum = sample_sum + elapsed;
      if (kept_samples < WINDOW_DEPTH) begin
        kept_samples++;
      end
    end
    if (frames_seen != RATE_MAX) begin
      frames_seen++;
    end
    // The accumulator takes the average from before this tick.
    average_acc = average_acc + prior;
    if (average_acc > {1'b0, second_ticks}) begin
      held_rate   = frames_seen;
      frames_seen = '0;
      average_acc = '0;
    end
    running_average = (kept_samples != 0) ? stamp_t'(sample_sum / kept_samples) : '0;
    res.average_elapsed = running_average;
    res.frame_rate      = held_rate;
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    frame_result_t want;
    frame_result_t got;
    if (rst) begin
      second_ticks    = TPS_RESET;
      prev_stamp      = '0;
      running_average = '0;
      kept_samples    = 0;
      sample_sum      = '0;
      frames_seen     = '0;
      held_rate       = '0;
      average_acc     = '0;
      awaited_results.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        second_ticks = cfg_ch.ticks_per_second;
      end
      if (frame_ch.valid && frame_ch.ready) begin
        awaited_results.push_back(average_frame(frame_ch.timestamp));
      end
      if (result_ch.valid && result_ch.ready) begin
        got.average_elapsed = result_ch.average_elapsed;
        got.frame_rate      = result_ch.frame_rate;
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: average_elapsed %0d frame_rate %0d",
                   $time, got.average_elapsed, got.frame_rate);
        end else begin
          want = awaited_results.pop_front();
          if (got.average_elapsed !== want.average_elapsed) begin
            errors++;
            $display("%0t: average_elapsed expected %0d, actual %0d",
                     $time, want.average_elapsed, got.average_elapsed);
          end
          if (got.frame_rate !== want.frame_rate) begin
            errors++;
            $display("%0t: frame_rate expected %0d, actual %0d",
                     $time, want.frame_rate, got.frame_rate);
          end
        end
      end
    end
    fail_count      <= errors;
    pending_results <= awaited_results.size();
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top of the frame time averager: clock, reset, stamp and register
// stimulus, result receiver and the verdict.
// Depends on fta_pkg, fta_channels, fta_checker and the frame_time_averager RTL.
`timescale 1ns / 1ps

module tb;
  import fta_pkg::*;

  localparam int WINDOW_DEPTH = 16;
  // The limit is several times the length of the slowest run.
  localparam int CYCLE_LIMIT  = 400000;
  // Long enough for one tick to pass the divider and reach the output.
  localparam int SETTLE       = 60;
  localparam int LONG_HOLD    = 400;

  logic clk;
  logic rst;

  fta_in_if  frame_ch ();
  fta_out_if result_ch ();
  fta_cfg_if cfg_ch ();

  int     fail_count;
  int     pending_results;
  int     cycles;

  // Set by the stimulus; the receiver process picks it up and then clears it.
  bit     long_hold;
  // In the closing phase neither side idles.
  bit     calm;
  stamp_t last_sent;

  // Directed stamps under the reset value of the rate window: the very first
  // tick (measured from a zero stamp), a repeated stamp, elapsed times just
  // inside one second, an outlier, timer wrap-round and alternating bit
  // patterns so that every stamp bit toggles.
  stamp_t directed_stamps[$] = '{
    32'h0000_0000, 32'h0000_0000, 32'h0000_03E7, 32'h0000_07CF,
    32'hFFFF_FFFF, 32'h0000_0100, 32'h0000_0200, 32'h0000_0300,
    32'hFFFF_FF00, 32'hFFFF_FFF0, 32'h0000_00A0, 32'h5555_5555,
    32'hAAAA_AAAA, 32'h8000_0000, 32'h8000_012C, 32'h8000_0258
  };

  frame_time_averager #(.WINDOW_DEPTH(WINDOW_DEPTH)) uut (
    .clk        (clk),
    .rst        (rst),
    .frame_in   (frame_ch),
    .result_out (result_ch),
    .cfg        (cfg_ch)
  );

  fta_checker #(.WINDOW_DEPTH(WINDOW_DEPTH)) checker_i (
    .clk             (clk),
    .rst             (rst),
    .frame_ch        (frame_ch),
    .result_ch       (result_ch),
    .cfg_ch          (cfg_ch),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The watchdog ends a run that hangs; it never fires in a correct run.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Result receiver. Each pass drives ready once and then waits on the clock
  // before the next pass, so ready never sees two assignments in one time step. A long
  // hold keeps ready low while the sender carries on offering stamps, which
  // fills the block and makes it refuse further ticks.
  initial begin
    forever begin
      if (long_hold) begin
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offers one stamp and returns at the edge where it is transferred. Valid is
  // left high so that a following stamp goes out back to back; an idle burst
  // lowers it first and raises it again only edges later.
  task automatic offer_stamp(input stamp_t stamp);
    if (!calm && $urandom_range(0, 3) == 0) begin
      frame_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    frame_ch.valid     <= 1'b1;
    frame_ch.timestamp <= stamp;
    last_sent = stamp;
    do @(posedge clk); while (!frame_ch.ready);
  endtask

  // Stops offering and waits until every predicted result has come back. The
  // pending count is registered and lags, so the first look waits on the clock.
  task automatic await_results();
    frame_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // Writes the rate window once the block has gone quiet.
  task automatic set_rate_window(input stamp_t ticks);
    await_results();
    repeat (SETTLE) @(posedge clk);
    cfg_ch.ticks_per_second <= ticks;
    cfg_ch.valid            <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // A run of frame ticks. Most follow the previous stamp by the period give or
  // take some jitter, so that the samples are kept and the window fills and rolls
  // over. Noise stamps are fully random, and skips land beyond the jitter band, at
  // the period plus three times the jitter plus one tick.
  task automatic frame_stream(input int count, input stamp_t period,
                              input stamp_t jitter, input int noise_pct,
                              input int skip_pct);
    int     pick;
    stamp_t stamp;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < noise_pct) begin
        stamp = $urandom();
      end else if (pick < noise_pct + skip_pct) begin
        stamp = last_sent + period + 3 * jitter + 1;
      end else begin
        stamp = last_sent + period - jitter + $urandom_range(0, 2 * jitter);
      end
      offer_stamp(stamp);
    end
  endtask

  initial begin : stimulus
    stamp_t steady_period;
    stamp_t window_ticks;
    calm      = 1'b0;
    long_hold = 1'b0;
    last_sent = '0;
    rst                     <= 1'b1;
    frame_ch.valid          <= 1'b0;
    frame_ch.timestamp      <= '0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.ticks_per_second <= TPS_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_stamps[i]) begin
      offer_stamp(directed_stamps[i]);
    end

    // The reset value written back explicitly, with steady frames.
    set_rate_window(TPS_RESET);
    frame_stream(120, $urandom_range(100, 900), $urandom_range(0, 150), 10, 5);

    // A zero window keeps no sample at all; the old average stays and the rate
    // latches on every tick once the accumulated average is nonzero.
    set_rate_window('0);
    frame_stream(30, 500, 100, 10, 5);

    // The widest window keeps nearly everything, so random stamps drive the
    // window sum and the accumulator towards their top bits. A constant
    // period at the end leaves the average equal to that period.
    set_rate_window('1);
    frame_stream(100, 0, 0, 100, 0);
    steady_period = $urandom_range(1000, 100000);
    frame_stream(20, steady_period, 0, 0, 0);

    // A window of one tick keeps only elapsed times equal to the average;
    // the skips land one tick off and are thrown out.
    set_rate_window(1);
    frame_stream(50, steady_period, 0, 0, 10);

    // Random windows at growing scales. The first one starts with a long
    // receiver stall while stamps keep being offered.
    for (int k = 0; k < 3; k++) begin
      window_ticks = $urandom_range(16 << (8 * k), 4096 << (8 * k));
      set_rate_window(window_ticks);
      if (k == 0) begin
        long_hold = 1'b1;
      end
      frame_stream(90, $urandom_range(1, window_ticks),
                   $urandom_range(0, window_ticks / 4), 10, 5);
    end

    // Closing phase at full rate on both sides.
    set_rate_window($urandom_range(32'h1000_0000, 32'hFFFF_FFFE));
    calm = 1'b1;
    frame_stream(100, $urandom_range(1, 1 << 24), $urandom_range(0, 1 << 20), 5, 5);

    await_results();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
